@@ sv/assert_macros.svh @@
// Assertion macros for the cache level RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked at every rising clock edge outside reset
`define CLL_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("%m: assertion failed");
// Property checked on the cycle right after a reset cycle
`define CLL_ASSERT_RST(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) (!rstn) |=> (prop)) \
        else $error("%m: reset check failed");
`else
`define CLL_ASSERT(lbl, clk, rstn, prop)
`define CLL_ASSERT_RST(lbl, clk, rstn, prop)
`endif
`endif

@@ sv/cll_pkg.sv @@
// Shared types and constants for the fully associative cache level
package cll_pkg;

    localparam int KEY_BITS      = 32;
    localparam int DATA_BITS     = 32;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 5;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_POLICY_MODE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CAPACITY    = 2'd1;

    localparam logic [CFG_DATA_BITS-1:0] CAPACITY_RESET = 5'd16;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    localparam logic POLICY_LRU = 1'b0;
    localparam logic POLICY_LFU = 1'b1;

    typedef enum logic [1:0] {
        CNT_KEEP,
        CNT_ONE,
        CNT_INC
    } cnt_op_t;

    // what the update sweep does to each entry
    typedef struct packed {
        logic    touch_rr;
        logic    touch_ir;
        logic    inc_all;
        logic    write_key;
        logic    write_data;
        cnt_op_t cnt_op;
    } upd_ctrl_t;

endpackage

@@ sv/cll_store.sv @@
// Entry storage: per-field memories with registered read, valid bits in flops
module cll_store #(
    parameter int ENTRIES    = 16,
    parameter int RANK_BITS  = 4,
    parameter int COUNT_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [$clog2(ENTRIES)-1:0]    rd_addr,
    output logic                          rd_valid,
    output logic [cll_pkg::KEY_BITS-1:0]  rd_key,
    output logic [cll_pkg::DATA_BITS-1:0] rd_data,
    output logic [RANK_BITS-1:0]          rd_rr,
    output logic [RANK_BITS-1:0]          rd_ir,
    output logic [COUNT_BITS-1:0]         rd_cnt,
    input  logic                          wr_en,
    input  logic [$clog2(ENTRIES)-1:0]    wr_addr,
    input  logic [cll_pkg::KEY_BITS-1:0]  wr_key,
    input  logic [cll_pkg::DATA_BITS-1:0] wr_data,
    input  logic [RANK_BITS-1:0]          wr_rr,
    input  logic [RANK_BITS-1:0]          wr_ir,
    input  logic [COUNT_BITS-1:0]         wr_cnt,
    input  logic                          set_en,
    input  logic [$clog2(ENTRIES)-1:0]    set_idx
);

    logic [ENTRIES-1:0] valid_reg;

    logic [cll_pkg::KEY_BITS-1:0]  key_mem  [ENTRIES];
    logic [cll_pkg::DATA_BITS-1:0] data_mem [ENTRIES];
    logic [RANK_BITS-1:0]          rr_mem   [ENTRIES];
    logic [RANK_BITS-1:0]          ir_mem   [ENTRIES];
    logic [COUNT_BITS-1:0]         cnt_mem  [ENTRIES];

    logic                          rd_valid_reg;
    logic [cll_pkg::KEY_BITS-1:0]  rd_key_reg;
    logic [cll_pkg::DATA_BITS-1:0] rd_data_reg;
    logic [RANK_BITS-1:0]          rd_rr_reg;
    logic [RANK_BITS-1:0]          rd_ir_reg;
    logic [COUNT_BITS-1:0]         rd_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (set_en) begin
            valid_reg[set_idx] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_mem[wr_addr]  <= wr_key;
            data_mem[wr_addr] <= wr_data;
            rr_mem[wr_addr]   <= wr_rr;
            ir_mem[wr_addr]   <= wr_ir;
            cnt_mem[wr_addr]  <= wr_cnt;
        end
        rd_valid_reg <= valid_reg[rd_addr];
        rd_key_reg   <= key_mem[rd_addr];
        rd_data_reg  <= data_mem[rd_addr];
        rd_rr_reg    <= rr_mem[rd_addr];
        rd_ir_reg    <= ir_mem[rd_addr];
        rd_cnt_reg   <= cnt_mem[rd_addr];
    end

    assign rd_valid = rd_valid_reg;
    assign rd_key   = rd_key_reg;
    assign rd_data  = rd_data_reg;
    assign rd_rr    = rd_rr_reg;
    assign rd_ir    = rd_ir_reg;
    assign rd_cnt   = rd_cnt_reg;

endmodule

@@ sv/cll_entry_unit.sv @@
// Shared per-entry unit: key match, victim compare and rank/count update
module cll_entry_unit #(
    parameter int RANK_BITS  = 4,
    parameter int COUNT_BITS = 16
) (
    input  logic                          policy,
    input  logic [cll_pkg::KEY_BITS-1:0]  req_key,
    input  logic [cll_pkg::DATA_BITS-1:0] req_data,
    input  logic                          cur_valid,
    input  logic [cll_pkg::KEY_BITS-1:0]  cur_key,
    input  logic [cll_pkg::DATA_BITS-1:0] cur_data,
    input  logic [RANK_BITS-1:0]          cur_rr,
    input  logic [RANK_BITS-1:0]          cur_ir,
    input  logic [COUNT_BITS-1:0]         cur_cnt,
    input  logic                          best_have,
    input  logic [RANK_BITS-1:0]          best_rr,
    input  logic [RANK_BITS-1:0]          best_ir,
    input  logic [COUNT_BITS-1:0]         best_cnt,
    input  cll_pkg::upd_ctrl_t            ctrl,
    input  logic                          is_target,
    input  logic [RANK_BITS-1:0]          rr_ref,
    input  logic [RANK_BITS-1:0]          ir_ref,
    output logic                          key_match,
    output logic                          best_take,
    output logic                          needs_write,
    output logic [cll_pkg::KEY_BITS-1:0]  new_key,
    output logic [cll_pkg::DATA_BITS-1:0] new_data,
    output logic [RANK_BITS-1:0]          new_rr,
    output logic [RANK_BITS-1:0]          new_ir,
    output logic [COUNT_BITS-1:0]         new_cnt
);

    logic better;
    logic rr_bump;
    logic ir_bump;

    always_comb begin
        key_match = cur_valid && (cur_key == req_key);

        // LFU ties go to the older insertion (higher insertion rank)
        if (policy == cll_pkg::POLICY_LRU) begin
            better = cur_rr > best_rr;
        end else begin
            better = (cur_cnt < best_cnt) || ((cur_cnt == best_cnt) && (cur_ir > best_ir));
        end
        best_take = cur_valid && (!best_have || better);

        // entries ranked ahead of the reference slot (all entries with inc_all) move back by one
        rr_bump = ctrl.touch_rr && (ctrl.inc_all || (cur_rr < rr_ref));
        ir_bump = ctrl.touch_ir && (ctrl.inc_all || (cur_ir < ir_ref));

        needs_write = cur_valid || is_target;

        if (is_target) begin
            new_key  = ctrl.write_key ? req_key : cur_key;
            new_data = ctrl.write_data ? req_data : cur_data;
            new_rr   = ctrl.touch_rr ? '0 : cur_rr;
            new_ir   = ctrl.touch_ir ? '0 : cur_ir;
            unique case (ctrl.cnt_op)
                cll_pkg::CNT_KEEP: new_cnt = cur_cnt;
                cll_pkg::CNT_ONE:  new_cnt = COUNT_BITS'(1);
                cll_pkg::CNT_INC:  new_cnt = (cur_cnt != '1) ? cur_cnt + COUNT_BITS'(1) : cur_cnt;
                default:           new_cnt = cur_cnt;
            endcase
        end else begin
            new_key  = cur_key;
            new_data = cur_data;
            new_rr   = rr_bump ? cur_rr + RANK_BITS'(1) : cur_rr;
            new_ir   = ir_bump ? cur_ir + RANK_BITS'(1) : cur_ir;
            new_cnt  = cur_cnt;
        end
    end

endmodule

@@ sv/cache_level_lru_lfu.sv @@
// Fully associative cache level with LRU/LFU replacement, top level
//
//  port group   handshake          contents
//  cfg_*        cfg_we only        register index and write data
//  s_*          s_valid/s_ready    operation, lookup_key, write_data
//  m_*          m_valid/m_ready    hit, read_data, evicted, evicted_key
//
// A request runs from accept to result as one sweep over the entry memories to
// match and pick a victim, a decision state and a second read-modify-write
// sweep to update ranks and counts; a get miss skips the second sweep. The
// entry unit handles one entry per cycle. s_ready is high only while idle. A
// finished word waits in the output register; a new request is taken
// meanwhile. Reset is synchronous and clears the valid bits at once; no
// clearing pass is needed.
`include "assert_macros.svh"

module cache_level_lru_lfu #(
    parameter int ENTRIES    = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [cll_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [cll_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_operation,
    input  logic [cll_pkg::KEY_BITS-1:0]      s_lookup_key,
    input  logic [cll_pkg::DATA_BITS-1:0]     s_write_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_hit,
    output logic [cll_pkg::DATA_BITS-1:0]     m_read_data,
    output logic                              m_evicted,
    output logic [cll_pkg::KEY_BITS-1:0]      m_evicted_key
);

    localparam int IDX_BITS   = $clog2(ENTRIES);
    localparam int RANK_BITS  = IDX_BITS;
    localparam int SWEEP_BITS = $clog2(ENTRIES + 1);
    localparam int CMP_BITS   = (SWEEP_BITS > cll_pkg::CFG_DATA_BITS) ?
                                SWEEP_BITS : cll_pkg::CFG_DATA_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_UPDATE,
        S_RESULT
    } state_t;

    // control
    state_t                            state_reg, state_next;
    logic [SWEEP_BITS-1:0]             cnt_reg, cnt_next;
    logic                              m_valid_reg, m_valid_next;
    logic                              policy_reg;
    logic [cll_pkg::CFG_DATA_BITS-1:0] cap_reg;

    // request and sweep results
    logic                              op_reg, op_next;
    logic [cll_pkg::KEY_BITS-1:0]      key_reg, key_next;
    logic [cll_pkg::DATA_BITS-1:0]     wdata_reg, wdata_next;
    logic [SWEEP_BITS-1:0]             occ_reg, occ_next;
    logic                              found_reg, found_next;
    logic [IDX_BITS-1:0]               slot_reg, slot_next;
    logic [cll_pkg::DATA_BITS-1:0]     hit_data_reg, hit_data_next;
    logic [RANK_BITS-1:0]              hit_rr_reg, hit_rr_next;
    logic [RANK_BITS-1:0]              hit_ir_reg, hit_ir_next;
    logic                              free_have_reg, free_have_next;
    logic [IDX_BITS-1:0]               free_idx_reg, free_idx_next;
    logic                              vict_have_reg, vict_have_next;
    logic [IDX_BITS-1:0]               vict_idx_reg, vict_idx_next;
    logic [RANK_BITS-1:0]              vict_rr_reg, vict_rr_next;
    logic [RANK_BITS-1:0]              vict_ir_reg, vict_ir_next;
    logic [COUNT_BITS-1:0]             vict_cnt_reg, vict_cnt_next;
    logic [cll_pkg::KEY_BITS-1:0]      vict_key_reg, vict_key_next;
    cll_pkg::upd_ctrl_t                ctrl_reg, ctrl_next;
    logic [IDX_BITS-1:0]               tgt_reg, tgt_next;
    logic [RANK_BITS-1:0]              rr_ref_reg, rr_ref_next;
    logic [RANK_BITS-1:0]              ir_ref_reg, ir_ref_next;
    logic                              res_hit_reg, res_hit_next;
    logic [cll_pkg::DATA_BITS-1:0]     res_rd_reg, res_rd_next;
    logic                              res_ev_reg, res_ev_next;
    logic [cll_pkg::KEY_BITS-1:0]      res_evk_reg, res_evk_next;
    logic                              m_hit_reg, m_hit_next;
    logic [cll_pkg::DATA_BITS-1:0]     m_rd_reg, m_rd_next;
    logic                              m_ev_reg, m_ev_next;
    logic [cll_pkg::KEY_BITS-1:0]      m_evk_reg, m_evk_next;

    // store and entry unit
    logic [IDX_BITS-1:0]               rd_addr;
    logic [IDX_BITS-1:0]               proc_idx;
    logic                              rd_valid;
    logic [cll_pkg::KEY_BITS-1:0]      rd_key;
    logic [cll_pkg::DATA_BITS-1:0]     rd_data;
    logic [RANK_BITS-1:0]              rd_rr;
    logic [RANK_BITS-1:0]              rd_ir;
    logic [COUNT_BITS-1:0]             rd_cnt;
    logic                              wr_en;
    logic                              set_en;
    logic                              key_match;
    logic                              best_take;
    logic                              needs_write;
    logic [cll_pkg::KEY_BITS-1:0]      new_key;
    logic [cll_pkg::DATA_BITS-1:0]     new_data;
    logic [RANK_BITS-1:0]              new_rr;
    logic [RANK_BITS-1:0]              new_ir;
    logic [COUNT_BITS-1:0]             new_cnt;

    logic                              sweep_last;
    logic                              entry_live;
    logic [CMP_BITS-1:0]               cap_ext;
    logic [CMP_BITS-1:0]               cap_eff;
    logic                              level_full;

    assign sweep_last = cnt_reg == SWEEP_BITS'(ENTRIES);
    assign entry_live = cnt_reg != '0;
    assign rd_addr    = sweep_last ? '0 : cnt_reg[IDX_BITS-1:0];
    assign proc_idx   = IDX_BITS'(cnt_reg - SWEEP_BITS'(1));

    // capacity of zero acts as one, above ENTRIES acts as ENTRIES
    assign cap_ext    = CMP_BITS'(cap_reg);
    assign cap_eff    = (cap_ext == '0) ? CMP_BITS'(1) :
                        (cap_ext > CMP_BITS'(ENTRIES)) ? CMP_BITS'(ENTRIES) : cap_ext;
    assign level_full = CMP_BITS'(occ_reg) >= cap_eff;

    assign wr_en = (state_reg == S_UPDATE) && entry_live && needs_write;

    cll_store #(
        .ENTRIES   (ENTRIES),
        .RANK_BITS (RANK_BITS),
        .COUNT_BITS(COUNT_BITS)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_addr (rd_addr),
        .rd_valid(rd_valid),
        .rd_key  (rd_key),
        .rd_data (rd_data),
        .rd_rr   (rd_rr),
        .rd_ir   (rd_ir),
        .rd_cnt  (rd_cnt),
        .wr_en   (wr_en),
        .wr_addr (proc_idx),
        .wr_key  (new_key),
        .wr_data (new_data),
        .wr_rr   (new_rr),
        .wr_ir   (new_ir),
        .wr_cnt  (new_cnt),
        .set_en  (set_en),
        .set_idx (free_idx_reg)
    );

    cll_entry_unit #(
        .RANK_BITS (RANK_BITS),
        .COUNT_BITS(COUNT_BITS)
    ) u_unit (
        .policy     (policy_reg),
        .req_key    (key_reg),
        .req_data   (wdata_reg),
        .cur_valid  (rd_valid),
        .cur_key    (rd_key),
        .cur_data   (rd_data),
        .cur_rr     (rd_rr),
        .cur_ir     (rd_ir),
        .cur_cnt    (rd_cnt),
        .best_have  (vict_have_reg),
        .best_rr    (vict_rr_reg),
        .best_ir    (vict_ir_reg),
        .best_cnt   (vict_cnt_reg),
        .ctrl       (ctrl_reg),
        .is_target  (proc_idx == tgt_reg),
        .rr_ref     (rr_ref_reg),
        .ir_ref     (ir_ref_reg),
        .key_match  (key_match),
        .best_take  (best_take),
        .needs_write(needs_write),
        .new_key    (new_key),
        .new_data   (new_data),
        .new_rr     (new_rr),
        .new_ir     (new_ir),
        .new_cnt    (new_cnt)
    );

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        op_next        = op_reg;
        key_next       = key_reg;
        wdata_next     = wdata_reg;
        occ_next       = occ_reg;
        found_next     = found_reg;
        slot_next      = slot_reg;
        hit_data_next  = hit_data_reg;
        hit_rr_next    = hit_rr_reg;
        hit_ir_next    = hit_ir_reg;
        free_have_next = free_have_reg;
        free_idx_next  = free_idx_reg;
        vict_have_next = vict_have_reg;
        vict_idx_next  = vict_idx_reg;
        vict_rr_next   = vict_rr_reg;
        vict_ir_next   = vict_ir_reg;
        vict_cnt_next  = vict_cnt_reg;
        vict_key_next  = vict_key_reg;
        ctrl_next      = ctrl_reg;
        tgt_next       = tgt_reg;
        rr_ref_next    = rr_ref_reg;
        ir_ref_next    = ir_ref_reg;
        res_hit_next   = res_hit_reg;
        res_rd_next    = res_rd_reg;
        res_ev_next    = res_ev_reg;
        res_evk_next   = res_evk_reg;
        m_hit_next     = m_hit_reg;
        m_rd_next      = m_rd_reg;
        m_ev_next      = m_ev_reg;
        m_evk_next     = m_evk_reg;
        set_en         = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next        = s_operation;
                    key_next       = s_lookup_key;
                    wdata_next     = s_write_data;
                    occ_next       = '0;
                    found_next     = 1'b0;
                    free_have_next = 1'b0;
                    vict_have_next = 1'b0;
                    cnt_next       = '0;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN: begin
                // read data is registered and belongs to the address of the previous cycle
                if (entry_live) begin
                    if (rd_valid) begin
                        occ_next = occ_reg + SWEEP_BITS'(1);
                        if (key_match && !found_reg) begin
                            found_next    = 1'b1;
                            slot_next     = proc_idx;
                            hit_data_next = rd_data;
                            hit_rr_next   = rd_rr;
                            hit_ir_next   = rd_ir;
                        end
                        if (best_take) begin
                            vict_have_next = 1'b1;
                            vict_idx_next  = proc_idx;
                            vict_rr_next   = rd_rr;
                            vict_ir_next   = rd_ir;
                            vict_cnt_next  = rd_cnt;
                            vict_key_next  = rd_key;
                        end
                    end else if (!free_have_reg) begin
                        free_have_next = 1'b1;
                        free_idx_next  = proc_idx;
                    end
                end
                if (sweep_last) begin
                    state_next = S_DECIDE;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + SWEEP_BITS'(1);
                end
            end
            S_DECIDE: begin
                res_hit_next = found_reg;
                res_rd_next  = '0;
                res_ev_next  = 1'b0;
                res_evk_next = '0;
                ctrl_next    = '{touch_rr: 1'b0, touch_ir: 1'b0, inc_all: 1'b0,
                                 write_key: 1'b0, write_data: 1'b0,
                                 cnt_op: cll_pkg::CNT_KEEP};
                tgt_next     = slot_reg;
                rr_ref_next  = hit_rr_reg;
                ir_ref_next  = hit_ir_reg;
                state_next   = S_UPDATE;
                priority if (op_reg == cll_pkg::OP_GET) begin
                    if (found_reg) begin
                        res_rd_next = hit_data_reg;
                        if (policy_reg == cll_pkg::POLICY_LRU) begin
                            ctrl_next.touch_rr = 1'b1;
                        end else begin
                            ctrl_next.cnt_op = cll_pkg::CNT_INC;
                        end
                    end else begin
                        state_next = S_RESULT;
                    end
                end else if (found_reg) begin
                    ctrl_next.write_data = 1'b1;
                    ctrl_next.touch_rr   = 1'b1;
                    ctrl_next.touch_ir   = 1'b1;
                    ctrl_next.cnt_op     = cll_pkg::CNT_ONE;
                end else begin
                    ctrl_next.write_key  = 1'b1;
                    ctrl_next.write_data = 1'b1;
                    ctrl_next.touch_rr   = 1'b1;
                    ctrl_next.touch_ir   = 1'b1;
                    ctrl_next.cnt_op     = cll_pkg::CNT_ONE;
                    if (level_full) begin
                        // victim slot is reused; entries ranked ahead of it move back to close the gap
                        tgt_next     = vict_idx_reg;
                        rr_ref_next  = vict_rr_reg;
                        ir_ref_next  = vict_ir_reg;
                        res_ev_next  = 1'b1;
                        res_evk_next = vict_key_reg;
                    end else begin
                        tgt_next          = free_idx_reg;
                        ctrl_next.inc_all = 1'b1;
                        set_en            = 1'b1;
                    end
                end
                cnt_next = '0;
            end
            S_UPDATE: begin
                if (sweep_last) begin
                    state_next = S_RESULT;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + SWEEP_BITS'(1);
                end
            end
            S_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_hit_next   = res_hit_reg;
                    m_rd_next    = res_rd_reg;
                    m_ev_next    = res_ev_reg;
                    m_evk_next   = res_evk_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            m_hit_reg   <= 1'b0;
            m_rd_reg    <= '0;
            m_ev_reg    <= 1'b0;
            m_evk_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            m_hit_reg   <= m_hit_next;
            m_rd_reg    <= m_rd_next;
            m_ev_reg    <= m_ev_next;
            m_evk_reg   <= m_evk_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg <= cll_pkg::POLICY_LRU;
            cap_reg    <= cll_pkg::CAPACITY_RESET;
        end else if (cfg_we) begin
            if (cfg_index == cll_pkg::CFG_POLICY_MODE) begin
                policy_reg <= cfg_wdata[0];
            end else if (cfg_index == cll_pkg::CFG_CAPACITY) begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        wdata_reg     <= wdata_next;
        occ_reg       <= occ_next;
        found_reg     <= found_next;
        slot_reg      <= slot_next;
        hit_data_reg  <= hit_data_next;
        hit_rr_reg    <= hit_rr_next;
        hit_ir_reg    <= hit_ir_next;
        free_have_reg <= free_have_next;
        free_idx_reg  <= free_idx_next;
        vict_have_reg <= vict_have_next;
        vict_idx_reg  <= vict_idx_next;
        vict_rr_reg   <= vict_rr_next;
        vict_ir_reg   <= vict_ir_next;
        vict_cnt_reg  <= vict_cnt_next;
        vict_key_reg  <= vict_key_next;
        ctrl_reg      <= ctrl_next;
        tgt_reg       <= tgt_next;
        rr_ref_reg    <= rr_ref_next;
        ir_ref_reg    <= ir_ref_next;
        res_hit_reg   <= res_hit_next;
        res_rd_reg    <= res_rd_next;
        res_ev_reg    <= res_ev_next;
        res_evk_reg   <= res_evk_next;
    end

    assign s_ready       = state_reg == S_IDLE;
    assign m_valid       = m_valid_reg;
    assign m_hit         = m_hit_reg;
    assign m_read_data   = m_rd_reg;
    assign m_evicted     = m_ev_reg;
    assign m_evicted_key = m_evk_reg;

    `CLL_ASSERT(a_busy_after_accept, aclk, aresetn, (s_valid && s_ready) |=> !s_ready)
    `CLL_ASSERT(a_scan_to_decide, aclk, aresetn, (state_reg == S_SCAN && sweep_last) |=> (state_reg == S_DECIDE))
    `CLL_ASSERT(a_evict_not_hit, aclk, aresetn, (m_valid && m_evicted) |-> !m_hit)
    `CLL_ASSERT(a_evk_zero, aclk, aresetn, (m_valid && !m_evicted) |-> (m_evicted_key == '0))
    `CLL_ASSERT_RST(a_reset_idle, aclk, aresetn, !m_valid && s_ready)

endmodule

@@ tb/tb_cache_level_lru_lfu.sv @@
// Self-checking testbench for the LRU/LFU cache level: directed and random gets and puts
module tb_cache_level_lru_lfu;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRY_COUNT  = 16;
    localparam int DRAIN_CYCLES = 2 * ENTRY_COUNT + 8;
    localparam int CYCLE_LIMIT  = 1_000_000;

    // indexes past the two real registers, written to check that they are ignored
    localparam logic [cll_pkg::CFG_IDX_BITS-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [cll_pkg::CFG_IDX_BITS-1:0] CFG_SPARE_3 = 2'd3;

    logic                              aclk = 1'b0;
    logic                              aresetn;
    logic                              cfg_we;
    logic [cll_pkg::CFG_IDX_BITS-1:0]  cfg_index;
    logic [cll_pkg::CFG_DATA_BITS-1:0] cfg_wdata;
    logic                              s_valid;
    logic                              s_ready;
    logic                              s_operation;
    logic [cll_pkg::KEY_BITS-1:0]      s_lookup_key;
    logic [cll_pkg::DATA_BITS-1:0]     s_write_data;
    logic                              m_valid;
    logic                              m_ready;
    logic                              m_hit;
    logic [cll_pkg::DATA_BITS-1:0]     m_read_data;
    logic                              m_evicted;
    logic [cll_pkg::KEY_BITS-1:0]      m_evicted_key;

    bit idle_enable;

    typedef struct {
        logic                          hit;
        logic [cll_pkg::DATA_BITS-1:0] read_data;
        logic                          evicted;
        logic [cll_pkg::KEY_BITS-1:0]  evicted_key;
    } reply_t;

    // Mirror of the cache contents and policy state; predicts one reply per request.
    class cache_mirror;
        bit                          policy;
        bit [4:0]                    capacity;
        bit                          valid_q [ENTRY_COUNT];
        bit [cll_pkg::KEY_BITS-1:0]  key_q   [ENTRY_COUNT];
        bit [cll_pkg::DATA_BITS-1:0] data_q  [ENTRY_COUNT];
        int                          recency [ENTRY_COUNT];
        int                          age     [ENTRY_COUNT];
        bit [15:0]                   uses    [ENTRY_COUNT];
        reply_t                      awaited [$];
        int                          failures;

        function new();
            policy   = cll_pkg::POLICY_LRU;
            capacity = cll_pkg::CAPACITY_RESET;
            failures = 0;
            foreach (valid_q[i]) begin
                valid_q[i] = 1'b0;
                recency[i] = 0;
                age[i]     = 0;
                uses[i]    = '0;
            end
        endfunction

        function void write_register(bit [cll_pkg::CFG_IDX_BITS-1:0] idx,
                                     bit [cll_pkg::CFG_DATA_BITS-1:0] value);
            if (idx == cll_pkg::CFG_POLICY_MODE) begin
                policy = value[0];
            end else if (idx == cll_pkg::CFG_CAPACITY) begin
                capacity = value;
            end
        endfunction

        // rank 0 is most recent / newest; entries ahead of e slide back by one
        function void bring_front(int e, bit by_age);
            int r;
            r = by_age ? age[e] : recency[e];
            for (int i = 0; i < ENTRY_COUNT; i++) begin
                if (i != e && valid_q[i]) begin
                    if (by_age && age[i] < r) age[i]++;
                    if (!by_age && recency[i] < r) recency[i]++;
                end
            end
            if (by_age) age[e] = 0;
            else recency[e] = 0;
        endfunction

        function int pick_victim();
            int v;
            bit have;
            v = 0;
            have = 1'b0;
            for (int i = 0; i < ENTRY_COUNT; i++) begin
                if (valid_q[i]) begin
                    if (!have) begin
                        v = i;
                        have = 1'b1;
                    end else if (policy == cll_pkg::POLICY_LRU) begin
                        if (recency[i] > recency[v]) v = i;
                    end else if (uses[i] < uses[v] ||
                                 (uses[i] == uses[v] && age[i] > age[v])) begin
                        v = i;
                    end
                end
            end
            return v;
        endfunction

        function void note_request(bit op, bit [cll_pkg::KEY_BITS-1:0] key,
                                   bit [cll_pkg::DATA_BITS-1:0] wdata);
            reply_t r;
            int slot;
            int occ;
            int cap;
            bit found;
            r.hit         = 1'b0;
            r.read_data   = '0;
            r.evicted     = 1'b0;
            r.evicted_key = '0;
            slot  = 0;
            occ   = 0;
            found = 1'b0;
            cap = (capacity == 0) ? 1 : ((capacity > ENTRY_COUNT) ? ENTRY_COUNT : capacity);
            for (int i = 0; i < ENTRY_COUNT; i++) begin
                if (valid_q[i]) begin
                    occ++;
                    if (!found && key_q[i] == key) begin
                        found = 1'b1;
                        slot  = i;
                    end
                end
            end
            if (op == cll_pkg::OP_GET) begin
                if (found) begin
                    r.read_data = data_q[slot];
                    if (policy == cll_pkg::POLICY_LRU) bring_front(slot, 1'b0);
                    else if (uses[slot] != 16'hFFFF) uses[slot]++;
                end
            end else if (found) begin
                data_q[slot] = wdata;
                bring_front(slot, 1'b0);
                bring_front(slot, 1'b1);
                uses[slot] = 16'd1;
            end else begin
                if (occ >= cap) begin
                    slot = pick_victim();
                    r.evicted     = 1'b1;
                    r.evicted_key = key_q[slot];
                    valid_q[slot] = 1'b0;
                    for (int i = 0; i < ENTRY_COUNT; i++) begin
                        if (valid_q[i]) begin
                            if (recency[i] > recency[slot]) recency[i]--;
                            if (age[i] > age[slot]) age[i]--;
                        end
                    end
                end else begin
                    for (int i = ENTRY_COUNT - 1; i >= 0; i--)
                        if (!valid_q[i]) slot = i;
                end
                for (int i = 0; i < ENTRY_COUNT; i++) begin
                    if (valid_q[i]) begin
                        recency[i]++;
                        age[i]++;
                    end
                end
                valid_q[slot] = 1'b1;
                key_q[slot]   = key;
                data_q[slot]  = wdata;
                recency[slot] = 0;
                age[slot]     = 0;
                uses[slot]    = 16'd1;
            end
            r.hit = found;
            awaited.insert(awaited.size(), r);
        endfunction

        function void check_reply(logic hit, logic [cll_pkg::DATA_BITS-1:0] rd, logic ev,
                                  logic [cll_pkg::KEY_BITS-1:0] evk);
            reply_t e;
            if (awaited.size() == 0) begin
                $error("result word with no request outstanding");
                failures++;
                return;
            end
            e = awaited.pop_front();
            if (hit !== e.hit) begin
                $error("hit: expected %0d, got %0d", e.hit, hit);
                failures++;
            end
            if (rd !== e.read_data) begin
                $error("read_data: expected %h, got %h", e.read_data, rd);
                failures++;
            end
            if (ev !== e.evicted) begin
                $error("evicted: expected %0d, got %0d", e.evicted, ev);
                failures++;
            end
            if (evk !== e.evicted_key) begin
                $error("evicted_key: expected %h, got %h", e.evicted_key, evk);
                failures++;
            end
        endfunction
    endclass

    cache_mirror mirror;

    cache_level_lru_lfu dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_lookup_key  (s_lookup_key),
        .s_write_data  (s_write_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hit         (m_hit),
        .m_read_data   (m_read_data),
        .m_evicted     (m_evicted),
        .m_evicted_key (m_evicted_key)
    );

    always #5ns aclk = ~aclk;

    // no gap while idle_enable is clear; else mostly no gap, some short ones, a few long
    function automatic int pick_gap(int longest);
        int r;
        if (!idle_enable) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, longest);
    endfunction

    task automatic send_request(bit op, bit [cll_pkg::KEY_BITS-1:0] key,
                                bit [cll_pkg::DATA_BITS-1:0] wdata);
        int gap;
        gap = pick_gap(30);
        repeat (gap) begin
            @(negedge aclk);
            s_valid = 1'b0;
        end
        @(negedge aclk);
        s_valid      = 1'b1;
        s_operation  = op;
        s_lookup_key = key;
        s_write_data = wdata;
        do @(posedge aclk); while (!s_ready);
        mirror.note_request(op, key, wdata);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (mirror.awaited.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(bit [cll_pkg::CFG_IDX_BITS-1:0] idx,
                                  bit [cll_pkg::CFG_DATA_BITS-1:0] value);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(posedge aclk);
        mirror.write_register(idx, value);
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic run_phase(bit pol, bit [4:0] cap, bit idle, int count);
        bit [cll_pkg::KEY_BITS-1:0] pool [20];
        bit [3:0]                   junk;
        bit [31:0]                  spare_word;
        bit [cll_pkg::KEY_BITS-1:0] key;
        int                         pool_len;
        int                         cap_eff;
        int                         r;
        bit                         op;
        wait_drained();
        spare_word = $urandom;
        junk = spare_word[3:0];
        // upper bits of the policy word must not matter
        write_register(cll_pkg::CFG_POLICY_MODE, {junk, pol});
        write_register(cll_pkg::CFG_CAPACITY, cap);
        spare_word = $urandom;
        write_register(CFG_SPARE_2, spare_word[cll_pkg::CFG_DATA_BITS-1:0]);
        spare_word = $urandom;
        write_register(CFG_SPARE_3, spare_word[cll_pkg::CFG_DATA_BITS-1:0]);
        idle_enable = idle;
        cap_eff  = (cap == 0) ? 1 : ((cap > ENTRY_COUNT) ? ENTRY_COUNT : cap);
        pool_len = cap_eff + $urandom_range(1, 4);
        for (int i = 0; i < pool_len; i++) pool[i] = $urandom;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 39) pool[$urandom_range(0, pool_len - 1)] = $urandom;
            r   = $urandom_range(0, 99);
            key = pool[$urandom_range(0, pool_len - 1)];
            if (r < 5) key = $urandom;
            else if (r < 9) key = key ^ (32'd1 << $urandom_range(0, 31));
            op = ($urandom_range(0, 99) < ((pol == cll_pkg::POLICY_LFU) ? 35 : 45)) ?
                 cll_pkg::OP_PUT : cll_pkg::OP_GET;
            send_request(op, key, $urandom);
        end
    endtask

    // result side: random stalls on m_ready, check each word taken
    initial begin : drain
        int stall_left;
        m_ready    = 1'b0;
        stall_left = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_ready = 1'b0;
                stall_left--;
            end else begin
                m_ready    = 1'b1;
                stall_left = pick_gap(40);
            end
            @(posedge aclk);
            if (m_valid && m_ready)
                mirror.check_reply(m_hit, m_read_data, m_evicted, m_evicted_key);
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        mirror       = new();
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = cll_pkg::CFG_POLICY_MODE;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_operation  = cll_pkg::OP_GET;
        s_lookup_key = '0;
        s_write_data = '0;
        idle_enable  = 1'b1;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset config: LRU, full capacity; key and data extremes
        send_request(cll_pkg::OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(cll_pkg::OP_PUT, 32'h0000_0000, 32'h0000_0000);
        send_request(cll_pkg::OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(cll_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(cll_pkg::OP_GET, 32'h0000_0000, 32'h5555_5555);
        send_request(cll_pkg::OP_PUT, 32'h0000_0000, 32'hA5A5_5A5A);
        send_request(cll_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);
        send_request(cll_pkg::OP_GET, 32'h1234_5678, 32'h0000_0000);

        // capacity dropped below occupancy: each new put evicts exactly one
        wait_drained();
        write_register(cll_pkg::CFG_CAPACITY, 5'd1);
        send_request(cll_pkg::OP_PUT, 32'd1, 32'h1111_1111);
        send_request(cll_pkg::OP_PUT, 32'd2, 32'h2222_2222);
        send_request(cll_pkg::OP_GET, 32'd1, 32'h0000_0000);

        // LFU: lowest count goes, ties to the oldest insertion
        wait_drained();
        write_register(cll_pkg::CFG_POLICY_MODE, {4'b1010, cll_pkg::POLICY_LFU});
        write_register(cll_pkg::CFG_CAPACITY, 5'd3);
        write_register(CFG_SPARE_2, 5'b11111);
        write_register(CFG_SPARE_3, 5'b10101);
        send_request(cll_pkg::OP_PUT, 32'd3, 32'h3333_3333);
        send_request(cll_pkg::OP_GET, 32'd1, 32'h0000_0000);
        send_request(cll_pkg::OP_GET, 32'd1, 32'h0000_0000);
        send_request(cll_pkg::OP_GET, 32'd3, 32'h0000_0000);
        send_request(cll_pkg::OP_PUT, 32'd4, 32'h4444_4444);
        send_request(cll_pkg::OP_PUT, 32'd5, 32'h5555_5555);
        send_request(cll_pkg::OP_PUT, 32'd2, 32'h2020_2020);
        send_request(cll_pkg::OP_PUT, 32'd1, 32'h1010_1010);
        send_request(cll_pkg::OP_PUT, 32'd6, 32'h6666_6666);

        // back to LRU on kept ranks; zero capacity acts as one
        wait_drained();
        write_register(cll_pkg::CFG_POLICY_MODE, {4'b0000, cll_pkg::POLICY_LRU});
        write_register(cll_pkg::CFG_CAPACITY, 5'd0);
        send_request(cll_pkg::OP_PUT, 32'd7, 32'h7777_7777);
        send_request(cll_pkg::OP_GET, 32'd6, 32'h0000_0000);

        run_phase(cll_pkg::POLICY_LRU, 5'd16, 1'b1, 120);
        run_phase(cll_pkg::POLICY_LFU, 5'd16, 1'b1, 120);
        run_phase(cll_pkg::POLICY_LRU, 5'd1,  1'b0, 120);
        run_phase(cll_pkg::POLICY_LFU, 5'd2,  1'b1, 120);
        run_phase(cll_pkg::POLICY_LRU, 5'd31, 1'b1, 120);
        run_phase(cll_pkg::POLICY_LFU, 5'd0,  1'b0, 120);
        run_phase(cll_pkg::POLICY_LFU, 5'd5,  1'b1, 120);
        run_phase(cll_pkg::POLICY_LRU, 5'd9,  1'b1, 120);
        run_phase(cll_pkg::POLICY_LFU, 5'd17, 1'b1, 120);

        wait_drained();
        if (mirror.failures == 0 && mirror.awaited.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
